// ----- sv/pre_pkg.sv -----
// Package for the partition refinement engine: command codes, sequencer states
// and default sizing. No dependencies.
package pre_pkg;

  localparam int unsigned DEF_MAX_ELEMENTS = 256;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_MARK    = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MA, ST_MB, ST_MC, ST_MD, ST_ME, ST_MF,
    ST_P1A, ST_P1B, ST_P1C, ST_P1D,
    ST_P2A, ST_P2B, ST_P2C,
    ST_P3A, ST_P3B,
    ST_QA, ST_QB, ST_QC, ST_QD, ST_QE, ST_QF
  } pre_state_t;

endpackage

// ----- sv/partition_refinement_engine.sv -----
// Partition refinement engine: permutation split into contiguous classes,
// held in on-chip synchronous memories. Depends on pre_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tuser: cmd[1:0]; s_tdata: element[7:0];
//          |     |                    | s_tlast: last
//  m       | out | m_tvalid/m_tready  | m_tdata: value[7:0], class_start[15:8],
//          |     |                    |         class_end[23:16]
//  cfg     | in  | cfg_valid/cfg_ready| cfg_data: element_count[8:0]
//
// A read walks the query states; a mark walks the mark states and then the
// query states, with on last a split of three passes over the pending marks
// between them. Every step is a chain of dependent registered memory reads,
// walked by one sequencer. Restart sweeps all MAX_ELEMENTS entries, one per
// cycle. After reset the same sweep runs with s_tready low; cfg writes are
// taken at any time. The result register lets the next item enter while a
// result waits.
module partition_refinement_engine
  import pre_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // element[7:0]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // value[7:0], class_start[15:8], class_end[23:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // element_count
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned NW = AW + 1;

  // clamp element_count to 1..MAX_ELEMENTS
  function automatic logic [NW-1:0] clamp_n(input logic [8:0] ec);
    logic [31:0] v;
    v = 32'(ec);
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(MAX_ELEMENTS)) v = 32'(MAX_ELEMENTS);
    return NW'(v);
  endfunction

  // ---------------- memories ----------------
  logic [AW-1:0] order_mem  [MAX_ELEMENTS];
  logic [AW-1:0] place_mem  [MAX_ELEMENTS];
  logic [AW-1:0] clast_mem  [MAX_ELEMENTS];
  logic [NW-1:0] cfirst_mem [MAX_ELEMENTS];
  logic [AW-1:0] rbase_mem  [MAX_ELEMENTS];
  logic [AW-1:0] pend_mem   [MAX_ELEMENTS];
  logic          marked_mem [MAX_ELEMENTS];

  logic [AW-1:0] order_ra, order_rb, place_ra, clast_ra, cfirst_ra, rbase_ra;
  logic [AW-1:0] pend_ra, marked_ra;
  logic [AW-1:0] order_qa, order_qb, place_q, clast_q, rbase_q, pend_q;
  logic [NW-1:0] cfirst_q;
  logic          marked_q;

  logic          order_we, place_we, clast_we, cfirst_we, rbase_we, pend_we, marked_we;
  logic [AW-1:0] order_wa, place_wa, clast_wa, cfirst_wa, rbase_wa, pend_wa, marked_wa;
  logic [AW-1:0] order_wd, place_wd, clast_wd, rbase_wd, pend_wd;
  logic [NW-1:0] cfirst_wd;
  logic          marked_wd;

  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    order_qa <= order_mem[order_ra];
    order_qb <= order_mem[order_rb];
  end
  always_ff @(posedge clk) begin
    if (place_we) place_mem[place_wa] <= place_wd;
    place_q <= place_mem[place_ra];
  end
  always_ff @(posedge clk) begin
    if (clast_we) clast_mem[clast_wa] <= clast_wd;
    clast_q <= clast_mem[clast_ra];
  end
  always_ff @(posedge clk) begin
    if (cfirst_we) cfirst_mem[cfirst_wa] <= cfirst_wd;
    cfirst_q <= cfirst_mem[cfirst_ra];
  end
  always_ff @(posedge clk) begin
    if (rbase_we) rbase_mem[rbase_wa] <= rbase_wd;
    rbase_q <= rbase_mem[rbase_ra];
  end
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_q <= pend_mem[pend_ra];
  end
  always_ff @(posedge clk) begin
    if (marked_we) marked_mem[marked_wa] <= marked_wd;
    marked_q <= marked_mem[marked_ra];
  end

  // ---------------- control and working registers ----------------
  pre_state_t    state, state_next;
  logic [8:0]    element_count;
  logic [NW-1:0] active_n;
  logic [NW-1:0] cnt;        // pending marks in the open round
  logic [NW-1:0] i_r;        // sweep / list walk index
  logic          emit;       // sweep ends in a restart result
  logic [1:0]    cmd_r;
  logic [7:0]    el_r;
  logic          last_r, zero_r, restart_r;
  logic [AW-1:0] c_r, pe_r, x_r, a_r, v_r, t_r, y_r, rb_r;
  logic [NW-1:0] f_r;
  logic [7:0]    out_value, out_start, out_end;

  logic [1:0]    s_cmd;
  logic [7:0]    s_el;
  logic          s_ok, accept;
  logic [AW-1:0] el_a;
  logic          inr_mark, inr_read, mark_skip, p1_cut;
  logic [NW-1:0] q_start;
  pre_state_t    post_tgt, split_tgt;

  assign s_cmd  = s_tuser;
  assign s_el   = s_tdata;
  assign s_ok   = 32'(s_el) < 32'(active_n);
  assign accept = s_tvalid && s_tready;
  assign el_a   = AW'(el_r);

  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_end, out_start, out_value};

  // a class already opened in this round: its front-most marked element
  // still belongs to the same class
  assign inr_mark  = (f_r != '0) && marked_q && (clast_q == c_r);
  assign inr_read  = (f_r != '0) && (f_r <= active_n) && marked_q && (clast_q == t_r);
  assign q_start   = inr_read ? NW'(rb_r) : f_r;
  assign mark_skip = (cfirst_q >= active_n) || (cfirst_q > NW'(c_r));
  assign p1_cut    = (cfirst_q != '0) && (cfirst_q <= NW'(c_r));

  assign post_tgt  = zero_r ? ST_QF : ST_QA;
  assign split_tgt = (last_r && cnt != '0) ? ST_P1A : post_tgt;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_cmd == CMD_RESTART) state_next = ST_CLEAR;
          else if (s_cmd == CMD_MARK) state_next = ST_MA;
          else state_next = ST_QA;
        end
      end
      ST_CLEAR: begin
        if (i_r == NW'(MAX_ELEMENTS - 1)) state_next = emit ? ST_QF : ST_IDLE;
      end
      ST_MA:  state_next = zero_r ? split_tgt : ST_MB;
      ST_MB:  state_next = marked_q ? split_tgt : ST_MC;
      ST_MC:  state_next = mark_skip ? split_tgt : ST_MD;
      ST_MD:  state_next = ST_ME;
      ST_ME:  state_next = ST_MF;
      ST_MF:  state_next = split_tgt;
      ST_P1A: state_next = ST_P1B;
      ST_P1B: state_next = ST_P1C;
      ST_P1C: state_next = ST_P1D;
      ST_P1D: state_next = (NW'(i_r + 1'b1) == cnt) ? ST_P2A : ST_P1A;
      ST_P2A: state_next = ST_P2B;
      ST_P2B: state_next = ST_P2C;
      ST_P2C: state_next = (i_r == NW'(1)) ? ST_P3A : ST_P2A;
      ST_P3A: state_next = ST_P3B;
      ST_P3B: state_next = (NW'(i_r + 1'b1) == cnt) ? post_tgt : ST_P3A;
      ST_QA:  state_next = zero_r ? ST_QF : ST_QB;
      ST_QB:  state_next = (cmd_r == CMD_MARK) ? ST_QD : ST_QC;
      ST_QC:  state_next = ST_QD;
      ST_QD:  state_next = ST_QE;
      ST_QE:  state_next = ST_QF;
      ST_QF:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- memory ports and handshake ----------------
  always_comb begin
    s_tready  = (state == ST_IDLE);
    order_ra  = '0;  order_rb  = '0;  place_ra = '0;  clast_ra = '0;
    cfirst_ra = '0;  rbase_ra  = '0;  pend_ra  = '0;  marked_ra = '0;
    order_we  = 1'b0; place_we = 1'b0; clast_we = 1'b0; cfirst_we = 1'b0;
    rbase_we  = 1'b0; pend_we  = 1'b0; marked_we = 1'b0;
    order_wa  = '0; place_wa = '0; clast_wa = '0; cfirst_wa = '0;
    rbase_wa  = '0; pend_wa  = '0; marked_wa = '0;
    order_wd  = '0; place_wd = '0; clast_wd = '0; cfirst_wd = '0;
    rbase_wd  = '0; pend_wd  = '0; marked_wd = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        order_we  = 1'b1; order_wa  = i_r[AW-1:0]; order_wd  = i_r[AW-1:0];
        place_we  = 1'b1; place_wa  = i_r[AW-1:0]; place_wd  = i_r[AW-1:0];
        clast_we  = 1'b1; clast_wa  = i_r[AW-1:0]; clast_wd  = AW'(active_n - 1'b1);
        cfirst_we = 1'b1; cfirst_wa = i_r[AW-1:0];
        rbase_we  = 1'b1; rbase_wa  = i_r[AW-1:0];
        marked_we = 1'b1; marked_wa = i_r[AW-1:0];
      end
      ST_MA: begin
        marked_ra = el_a; clast_ra = el_a; place_ra = el_a;
      end
      ST_MB: cfirst_ra = clast_q;
      ST_MC: begin
        order_ra = AW'(cfirst_q);
        order_rb = AW'(cfirst_q - 1'b1);
      end
      ST_MD: begin
        marked_ra = order_qb; clast_ra = order_qb;
      end
      ST_ME: begin
        rbase_we  = !inr_mark; rbase_wa = c_r; rbase_wd = AW'(f_r);
        order_we  = 1'b1; order_wa = pe_r; order_wd = x_r;
        place_we  = 1'b1; place_wa = x_r;  place_wd = pe_r;
        cfirst_we = 1'b1; cfirst_wa = c_r; cfirst_wd = NW'(f_r + 1'b1);
        marked_we = 1'b1; marked_wa = el_a; marked_wd = 1'b1;
        pend_we   = (cnt < NW'(MAX_ELEMENTS)); pend_wa = AW'(cnt); pend_wd = el_a;
      end
      ST_MF: begin
        order_we = 1'b1; order_wa = AW'(f_r); order_wd = el_a;
        place_we = 1'b1; place_wa = el_a;     place_wd = AW'(f_r);
      end
      ST_P1A: pend_ra = i_r[AW-1:0];
      ST_P1B: clast_ra = pend_q;
      ST_P1C: cfirst_ra = clast_q;
      ST_P1D: begin
        clast_we = p1_cut; clast_wa = a_r; clast_wd = AW'(cfirst_q - 1'b1);
      end
      ST_P2A: pend_ra = AW'(i_r - 1'b1);
      ST_P2B: begin
        clast_ra = pend_q; place_ra = pend_q;
      end
      ST_P2C: begin
        cfirst_we = 1'b1; cfirst_wa = clast_q; cfirst_wd = NW'(place_q);
      end
      ST_P3A: pend_ra = i_r[AW-1:0];
      ST_P3B: begin
        marked_we = 1'b1; marked_wa = pend_q;
      end
      ST_QA: begin
        order_ra = el_a; place_ra = el_a; clast_ra = el_a;
      end
      ST_QB: begin
        clast_ra  = order_qa;
        cfirst_ra = clast_q; rbase_ra = clast_q;
      end
      ST_QC: begin
        cfirst_ra = clast_q; rbase_ra = clast_q;
      end
      ST_QD: order_rb = AW'(cfirst_q - 1'b1);
      ST_QE: begin
        marked_ra = order_qb; clast_ra = order_qb;
      end
      ST_QF: begin
        marked_ra = y_r; clast_ra = y_r;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      element_count <= 9'd256;
      active_n      <= clamp_n(9'd256);
      cnt           <= '0;
      i_r           <= '0;
      emit          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) element_count <= cfg_data;
      // result register: loaded in ST_QF once free, cleared when taken
      if ((state == ST_QF) && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r     <= s_cmd;
            el_r      <= s_el;
            last_r    <= s_tlast;
            restart_r <= (s_cmd == CMD_RESTART);
            zero_r    <= !((s_cmd == CMD_MARK) || (s_cmd == CMD_READ)) || !s_ok;
            i_r       <= '0;
            if (s_cmd == CMD_RESTART) begin
              active_n <= clamp_n(element_count);
              emit     <= 1'b1;
              cnt      <= '0;
            end
          end
        end
        ST_CLEAR: i_r <= NW'(i_r + 1'b1);
        ST_MB: begin
          c_r  <= clast_q;
          pe_r <= place_q;
        end
        ST_MC: f_r <= cfirst_q;
        ST_MD: x_r <= order_qa;
        ST_ME: if (cnt < NW'(MAX_ELEMENTS)) cnt <= NW'(cnt + 1'b1);
        ST_P1B: a_r <= pend_q;
        ST_P1C: c_r <= clast_q;
        ST_P1D: i_r <= NW'(i_r + 1'b1);
        ST_P2C: i_r <= NW'(i_r - 1'b1);
        ST_P3B: begin
          i_r <= NW'(i_r + 1'b1);
          if (NW'(i_r + 1'b1) == cnt) cnt <= '0;
        end
        ST_QB: begin
          if (cmd_r == CMD_MARK) begin
            v_r <= place_q;
            t_r <= clast_q;
          end else begin
            v_r <= order_qa;
          end
        end
        ST_QC: t_r <= clast_q;
        ST_QD: begin
          f_r  <= cfirst_q;
          rb_r <= rbase_q;
        end
        ST_QE: y_r <= order_qb;
        ST_QF: begin
          if (!m_tvalid || m_tready) begin
            emit     <= 1'b0;
            if (restart_r) begin
              out_value <= '0;
              out_start <= '0;
              out_end   <= 8'(active_n - 1'b1);
            end else if (zero_r) begin
              out_value <= '0;
              out_start <= '0;
              out_end   <= '0;
            end else begin
              out_value <= 8'(v_r);
              out_start <= 8'(q_start);
              out_end   <= 8'(t_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- checks ----------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= active_n)
    else $error("pending count exceeds element count");

  a_n_range: assert property (@(posedge clk) disable iff (rst)
    (active_n != '0) && (active_n <= NW'(MAX_ELEMENTS)))
    else $error("active element count out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer idle right after a transaction");

endmodule

// ----- bench/tb_partition_refinement_engine.sv -----
// Self-checking bench for partition_refinement_engine: directed, random and
// backpressure tests against an in-bench predictor. Depends on pre_pkg and the RTL.
`timescale 1ns / 100ps

module tb_partition_refinement_engine;
  import pre_pkg::*;

  localparam int unsigned NUM_ELEM  = 256;
  localparam int unsigned CYC_LIMIT = 3000000;
  localparam logic [1:0]  CMD_NONE  = 2'd3;  // unused opcode, result all zero

  typedef struct packed {
    logic [7:0] class_end;
    logic [7:0] class_start;
    logic [7:0] value;
  } class_info_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // element
  logic [1:0]  s_tuser = '0;   // cmd
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // value, class_start, class_end
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;  // element_count

  partition_refinement_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: permutation, per-class bookkeeping, open round
  // ---------------------------------------------------------------------
  logic [8:0] cnt_reg;                 // programmed element_count
  logic [8:0] live_n;                  // count in force since last restart
  logic [7:0] perm     [NUM_ELEM];     // position -> element
  logic [7:0] pos_of   [NUM_ELEM];     // element -> position
  logic [7:0] cls_end  [NUM_ELEM];     // element -> last position of class
  logic [8:0] cls_next [NUM_ELEM];     // class end -> next unmarked position
  logic [7:0] cls_base [NUM_ELEM];     // class end -> start saved at first mark
  logic [7:0] round_q  [NUM_ELEM];     // marks of the open round
  logic [8:0] round_len;
  logic       is_marked[NUM_ELEM];

  class_info_t result_q[$];            // results still owed by the block
  int          err_count = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          rcv_hold = 0;           // cycles of forced m_tready low

  function automatic void part_restart();
    logic [8:0] n;
    n = cnt_reg;
    if (n < 1) n = 1;
    if (n > NUM_ELEM) n = NUM_ELEM;
    live_n = n;
    for (int i = 0; i < NUM_ELEM; i++) begin
      perm[i]      = i[7:0];
      pos_of[i]    = i[7:0];
      cls_end[i]   = 8'(n - 1);
      cls_next[i]  = '0;
      cls_base[i]  = '0;
      round_q[i]   = '0;
      is_marked[i] = 1'b0;
    end
    round_len = '0;
  endfunction

  // class ending at c already took a mark in the open round
  function automatic bit class_open(logic [7:0] c);
    logic [8:0] f;
    logic [7:0] y;
    f = cls_next[c];
    if (f == 0 || f > live_n) return 1'b0;
    y = perm[8'(f - 1)];
    return is_marked[y] && cls_end[y] == c;
  endfunction

  function automatic logic [7:0] class_start_of(logic [7:0] c);
    return class_open(c) ? cls_base[c] : cls_next[c][7:0];
  endfunction

  function automatic void mark_elem(logic [7:0] e);
    logic [7:0] c, x, pe;
    logic [8:0] f;
    c = cls_end[e];
    f = cls_next[c];
    if (f >= live_n || f > c) return;
    if (!class_open(c)) cls_base[c] = f[7:0];
    x = perm[f[7:0]];
    pe = pos_of[e];
    perm[pe] = x;
    pos_of[x] = pe;
    perm[f[7:0]] = e;
    pos_of[e] = f[7:0];
    cls_next[c] = f + 1;
    is_marked[e] = 1'b1;
    if (round_len < NUM_ELEM) begin
      round_q[round_len[7:0]] = e;
      round_len++;
    end
  endfunction

  function automatic void split_round();
    logic [7:0] a, c;
    logic [8:0] f;
    for (int i = 0; i < round_len; i++) begin
      a = round_q[i];
      c = cls_end[a];
      f = cls_next[c];
      if (f >= 1 && f <= c) cls_end[a] = 8'(f - 1);
    end
    // backwards: the earliest mark of each class sets its start
    for (int i = round_len; i > 0; i--) begin
      a = round_q[i-1];
      cls_next[cls_end[a]] = {1'b0, pos_of[a]};
    end
    for (int i = 0; i < round_len; i++) is_marked[round_q[i]] = 1'b0;
    round_len = '0;
  endfunction

  function automatic class_info_t predict_item(logic [1:0] cmd, logic [7:0] el, logic lst);
    class_info_t r;
    r = '0;
    case (cmd)
      CMD_RESTART: begin
        part_restart();
        r.class_end = 8'(live_n - 1);
      end
      CMD_MARK: begin
        if (el < live_n && !is_marked[el]) mark_elem(el);
        if (lst) split_round();
        if (el < live_n) begin
          r.value       = pos_of[el];
          r.class_end   = cls_end[el];
          r.class_start = class_start_of(r.class_end);
        end
      end
      CMD_READ: begin
        if (el < live_n) begin
          r.value       = perm[el];
          r.class_end   = cls_end[r.value];
          r.class_start = class_start_of(r.class_end);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. Valid stays high between back-to-back items; it drops
  // only when a gap is taken, so each step sees one assignment.
  // ---------------------------------------------------------------------
  task automatic send_item(logic [1:0] cmd, logic [7:0] el, logic lst);
    int gap;
    gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= el;
    s_tuser  <= cmd;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    result_q.insert(result_q.size(), predict_item(cmd, el, lst));
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_count(logic [8:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cnt_reg = v;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: one transaction per edge with valid and ready high
  // ---------------------------------------------------------------------
  initial begin
    class_info_t want, got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        if (result_q.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (got.value != want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            err_count++;
          end
          if (got.class_start != want.class_start) begin
            $error("class_start: expected %0d, got %0d", want.class_start, got.class_start);
            err_count++;
          end
          if (got.class_end != want.class_end) begin
            $error("class_end: expected %0d, got %0d", want.class_end, got.class_end);
            err_count++;
          end
        end
      end
      if (rcv_hold > 0) begin
        rcv_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Edges of the fields and each special case of the command set
  task automatic test_directed();
    send_item(CMD_READ, 8'd0, 1'b0);
    send_item(CMD_READ, 8'd255, 1'b1);      // last on a read is ignored
    send_item(CMD_MARK, 8'd255, 1'b0);
    send_item(CMD_READ, 8'd0, 1'b0);        // open round: true class start
    send_item(CMD_MARK, 8'd255, 1'b0);      // repeated mark
    send_item(CMD_MARK, 8'd3, 1'b1);        // split
    send_item(CMD_READ, 8'd1, 1'b0);
    send_item(CMD_NONE, 8'd170, 1'b1);      // unused command
    send_item(CMD_RESTART, 8'd85, 1'b1);
    write_count(9'd4);
    send_item(CMD_RESTART, 8'd0, 1'b0);
    send_item(CMD_MARK, 8'd9, 1'b1);        // beyond count: all-zero result
    send_item(CMD_READ, 8'd200, 1'b0);      // read beyond count
    send_item(CMD_MARK, 8'd0, 1'b0);
    send_item(CMD_MARK, 8'd1, 1'b0);
    send_item(CMD_MARK, 8'd2, 1'b0);
    send_item(CMD_MARK, 8'd3, 1'b1);        // whole class marked: stays whole
    send_item(CMD_MARK, 8'd2, 1'b1);
    send_item(CMD_READ, 8'd3, 1'b0);
    write_count(9'd0);                      // clamps to one element
    send_item(CMD_RESTART, 8'd0, 1'b0);
    send_item(CMD_MARK, 8'd0, 1'b1);
    send_item(CMD_READ, 8'd0, 1'b0);
    write_count(9'd511);                    // clamps to the maximum
    send_item(CMD_RESTART, 8'd0, 1'b0);
    send_item(CMD_READ, 8'd255, 1'b0);
    wait_drain();
  endtask

  // Rounds of marks closed by last, reads in between, some noise
  task automatic test_random_rounds(int n_items, logic [8:0] count);
    int sent, k;
    logic [7:0] lim, el;
    write_count(count);
    send_item(CMD_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
    sent = 1;
    while (sent < n_items) begin
      lim = 8'(live_n - 1);
      if ($urandom_range(15) == 0) begin
        send_item(CMD_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
        el = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(lim));
        send_item(CMD_MARK, el, i == k - 1);
        sent++;
        if ($urandom_range(3) == 0) begin
          el = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(lim));
          send_item(CMD_READ, el, 1'($urandom_range(1)));
          sent++;
        end
      end
      if ($urandom_range(19) == 0) begin
        send_item(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
    end
    wait_drain();
  endtask

  // Receiver holds off long enough to fill the block and stall its input
  task automatic test_backpressure();
    write_count(9'd12);
    send_item(CMD_RESTART, 8'd0, 1'b0);
    wait_drain();
    rcv_hold = 600;
    for (int i = 0; i < 30; i++) send_item(i[0] ? CMD_READ : CMD_MARK,
                                          8'($urandom_range(11)), i % 5 == 4);
    wait_drain();                           // sender pause until all returned
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    cnt_reg = 9'd256;
    part_restart();
    @(posedge clk);

    snd_idle_pct = 38; rcv_idle_pct = 75;
    test_directed();
    test_random_rounds(500, 9'd8);

    snd_idle_pct = 75; rcv_idle_pct = 38;
    test_backpressure();
    test_random_rounds(500, 9'd37);

    snd_idle_pct = 0; rcv_idle_pct = 0;
    test_random_rounds(300, 9'd3);
    test_random_rounds(300, 9'd256);

    wait_drain();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pre_pkg.sv
sv/partition_refinement_engine.sv
bench/tb_partition_refinement_engine.sv
